>>> hdl/pwrseq_pkg.sv
// ----------------------------------------------------------------------------
// pwrseq_pkg
// Shared types, register map and constants of the power sequencer.
// ----------------------------------------------------------------------------
package pwrseq_pkg;

    localparam int SECONDS_WIDTH_DEF = 32;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // register index (paddr[3:2])
    localparam logic [1:0] REG_SHUTDOWN_LIMIT = 2'd0;
    localparam logic [1:0] REG_PRESS_EXPIRE   = 2'd1;
    localparam logic [1:0] REG_PRESS_WINDOW   = 2'd2;

    localparam logic [7:0] SHUTDOWN_LIMIT_RST = 8'd120;
    localparam logic [3:0] PRESS_EXPIRE_RST   = 4'd3;
    localparam logic [3:0] PRESS_WINDOW_RST   = 4'd2;

    // event kinds
    localparam logic [1:0] MODE_TICK  = 2'd0;
    localparam logic [1:0] MODE_PRESS = 2'd1;

    // reported state codes
    localparam logic [2:0] ST_BOOT  = 3'd0;
    localparam logic [2:0] ST_ON    = 3'd1;
    localparam logic [2:0] ST_WBUSY = 3'd2;
    localparam logic [2:0] ST_WDONE = 3'd3;
    localparam logic [2:0] ST_OFF   = 3'd4;

    // power output bits
    localparam int PO_HOST  = 0;
    localparam int PO_NFC   = 1;
    localparam int PO_SDREQ = 2;

    typedef enum logic [4:0] {
        PH_BOOT  = 5'b00001,
        PH_ON    = 5'b00010,
        PH_WBUSY = 5'b00100,
        PH_WDONE = 5'b01000,
        PH_OFF   = 5'b10000
    } phase_t;

    typedef struct packed {
        logic [1:0] mode;
        logic       power_ok;
        logic       shutdown_busy;
    } evt_word_t;

    typedef struct packed {
        logic [2:0] machine_state;
        logic       host_power;
        logic       nfc_power;
        logic       shutdown_request;
        logic       led_zero;
        logic       led_one;
        logic       led_two;
    } res_word_t;

    typedef struct packed {
        logic [7:0] shutdown_limit;
        logic [3:0] press_expire;
        logic [3:0] press_window;
    } cfg_t;

    typedef struct packed {
        logic head_valid;
        logic skid_valid;
    } obuf_sts_t;

    function automatic logic [2:0] phase_code(input phase_t ph);
        logic [2:0] code;
        case (ph)
            PH_BOOT:  code = ST_BOOT;
            PH_ON:    code = ST_ON;
            PH_WBUSY: code = ST_WBUSY;
            PH_WDONE: code = ST_WDONE;
            PH_OFF:   code = ST_OFF;
            default:  code = ST_BOOT;
        endcase
        return code;
    endfunction

endpackage

>>> hdl/pwrseq_if.sv
// ----------------------------------------------------------------------------
// pwrseq_if
// Valid/ready channels for wake events and result words.
// ----------------------------------------------------------------------------
interface pwrseq_evt_if;
    import pwrseq_pkg::*;

    logic      valid;
    logic      ready;
    evt_word_t word;

    modport source (output valid, output word, input ready);
    modport sink (input valid, input word, output ready);
endinterface

interface pwrseq_res_if;
    import pwrseq_pkg::*;

    logic      valid;
    logic      ready;
    res_word_t word;

    modport source (output valid, output word, input ready);
    modport sink (input valid, input word, output ready);
endinterface

>>> hdl/power_sequencer_fsm_core.sv
// ----------------------------------------------------------------------------
// power_sequencer_fsm_core
// Host board power sequencer driven by wake event words.
// ----------------------------------------------------------------------------
// Usage:
//   evt  : wake event words (mode, power_ok, shutdown_busy), valid/ready.
//   res  : one result word per event (state, power enables, shutdown
//          request, LED levels), valid/ready.
//   APB  : shutdown_limit at 0x0, press_expire at 0x4, press_window at 0x8;
//          write only while the block is idle.
// Result: an event's result word is registered in the result buffer behind
//   any words held there. Throughput: one event per cycle while evt.ready is
//   high; the pass is combinational logic between state registers and buffer.
// Stall: results queue in a two-word buffer (output plus skid register);
//   evt.ready drops only while both words are held.
// Reset: state returns to boot with seconds, press time, timeout, LEDs and
//   power outputs cleared; registers return to 120, 3 and 2.
// ----------------------------------------------------------------------------
module power_sequencer_fsm_core #(
    parameter int SECONDS_WIDTH = pwrseq_pkg::SECONDS_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    pwrseq_evt_if.sink                         evt,
    pwrseq_res_if.source                       res,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pwrseq_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [pwrseq_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [pwrseq_pkg::APB_DATA_W-1:0]  prdata,
    output logic                               pready
);
    import pwrseq_pkg::*;

    cfg_t      cfg;
    res_word_t step_word;
    obuf_sts_t obuf_sts;
    logic      accept;
    logic      evt_ready;

    assign evt.ready = evt_ready;
    assign accept    = evt.valid & evt_ready;

    pwrseq_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    pwrseq_step #(
        .SECONDS_WIDTH (SECONDS_WIDTH)
    ) u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .evt_word (evt.word),
        .cfg      (cfg),
        .res_word (step_word)
    );

    pwrseq_obuf u_obuf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (accept),
        .push_word  (step_word),
        .push_ready (evt_ready),
        .out_valid  (res.valid),
        .out_word   (res.word),
        .out_ready  (res.ready),
        .sts        (obuf_sts)
    );

`ifndef SYNTHESIS
    a_skid_implies_head: assert property (@(posedge clk) disable iff (!rst_n)
        obuf_sts.skid_valid |-> obuf_sts.head_valid)
        else $error("skid word held without output word");

    a_sdreq_only_wbusy: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.word.shutdown_request |-> res.word.machine_state == ST_WBUSY)
        else $error("shutdown request outside wait busy");

    a_off_host_down: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.word.machine_state == ST_OFF |-> !res.word.host_power)
        else $error("host power on in off state");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> obuf_sts.head_valid)
        else $error("accepted event left no result word");
`endif

endmodule

>>> hdl/pwrseq_cfg.sv
// ----------------------------------------------------------------------------
// pwrseq_cfg
// APB register block: shutdown limit, press expiry and press window.
// ----------------------------------------------------------------------------
module pwrseq_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pwrseq_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [pwrseq_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [pwrseq_pkg::APB_DATA_W-1:0]  prdata,
    output logic                               pready,
    output pwrseq_pkg::cfg_t                   cfg
);
    import pwrseq_pkg::*;

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite & pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.shutdown_limit <= SHUTDOWN_LIMIT_RST;
            cfg_reg.press_expire   <= PRESS_EXPIRE_RST;
            cfg_reg.press_window   <= PRESS_WINDOW_RST;
        end
        else if (wr_en)
        begin
            case (reg_idx)
                REG_SHUTDOWN_LIMIT: cfg_reg.shutdown_limit <= pwdata[7:0];
                REG_PRESS_EXPIRE:   cfg_reg.press_expire   <= pwdata[3:0];
                REG_PRESS_WINDOW:   cfg_reg.press_window   <= pwdata[3:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        prdata = '0;
        case (reg_idx)
            REG_SHUTDOWN_LIMIT: prdata[7:0] = cfg_reg.shutdown_limit;
            REG_PRESS_EXPIRE:   prdata[3:0] = cfg_reg.press_expire;
            REG_PRESS_WINDOW:   prdata[3:0] = cfg_reg.press_window;
            default:            prdata = '0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

>>> hdl/pwrseq_step.sv
// ----------------------------------------------------------------------------
// pwrseq_step
// Sequencer state and the single pass applied to each accepted wake event.
// ----------------------------------------------------------------------------
module pwrseq_step #(
    parameter int SECONDS_WIDTH = pwrseq_pkg::SECONDS_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    accept,
    input  pwrseq_pkg::evt_word_t   evt_word,
    input  pwrseq_pkg::cfg_t        cfg,
    output pwrseq_pkg::res_word_t   res_word
);
    import pwrseq_pkg::*;

    localparam int SW = SECONDS_WIDTH;

    phase_t          phase_reg,   phase_next;
    logic [SW-1:0]   sec_reg,     sec_next;
    logic [SW-1:0]   press_reg,   press_next;
    logic [7:0]      timeout_reg, timeout_next;
    logic [2:0]      led_reg,     led_next;
    logic [2:0]      po_reg,      po_next;

    logic [SW-1:0]   press_evt;
    logic [SW-1:0]   age;
    logic [SW-1:0]   press_live;
    logic            expired;

    always_comb
    begin
        sec_next  = sec_reg;
        press_evt = press_reg;
        if (evt_word.mode == MODE_TICK)
            sec_next = sec_reg + {{(SW-1){1'b0}}, 1'b1};
        else if (evt_word.mode == MODE_PRESS && press_reg == '0)
            press_evt = sec_reg;

        age        = sec_next - press_evt;
        press_live = (age > {{(SW-4){1'b0}}, cfg.press_expire}) ? '0 : press_evt;
        expired    = (timeout_reg <= 8'd1);

        phase_next   = phase_reg;
        press_next   = press_live;
        timeout_next = timeout_reg;
        led_next     = led_reg;
        po_next      = po_reg;

        case (phase_reg)
            PH_BOOT:
            begin
                led_next = 3'b111;
                if (evt_word.power_ok)
                begin
                    phase_next       = PH_ON;
                    po_next[PO_HOST] = 1'b1;
                    po_next[PO_NFC]  = 1'b1;
                end
                else
                    phase_next = PH_OFF;
            end
            PH_ON:
            begin
                led_next = {2'b00, ~led_reg[0]};
                if (!evt_word.power_ok ||
                    (press_live != '0 && age < {{(SW-4){1'b0}}, cfg.press_window}))
                begin
                    if (evt_word.power_ok)
                        press_next = '0;
                    po_next[PO_SDREQ] = 1'b1;
                    po_next[PO_NFC]   = 1'b0;
                    phase_next        = PH_WBUSY;
                    timeout_next      = cfg.shutdown_limit;
                end
            end
            PH_WBUSY:
            begin
                if (expired)
                begin
                    timeout_next      = 8'd0;
                    po_next[PO_SDREQ] = 1'b0;
                    phase_next        = PH_WDONE;
                end
                else
                begin
                    timeout_next = timeout_reg - 8'd1;
                    press_next   = '0;
                    led_next     = {1'b0, ~led_reg[1], 1'b0};
                    if (evt_word.shutdown_busy)
                    begin
                        po_next[PO_SDREQ] = 1'b0;
                        phase_next        = PH_WDONE;
                    end
                end
            end
            PH_WDONE:
            begin
                if (expired)
                begin
                    timeout_next     = 8'd0;
                    po_next[PO_HOST] = 1'b0;
                    phase_next       = PH_OFF;
                end
                else
                begin
                    timeout_next = timeout_reg - 8'd1;
                    press_next   = '0;
                    led_next     = {~led_reg[2], 2'b00};
                    if (!evt_word.shutdown_busy)
                    begin
                        po_next[PO_HOST] = 1'b0;
                        phase_next       = PH_OFF;
                    end
                end
            end
            PH_OFF:
            begin
                led_next = 3'b000;
                if (press_live != '0)
                begin
                    press_next = '0;
                    if (evt_word.power_ok)
                    begin
                        po_next[PO_HOST] = 1'b1;
                        po_next[PO_NFC]  = 1'b1;
                        phase_next       = PH_ON;
                    end
                end
            end
            default:
                phase_next = PH_BOOT;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_BOOT;
            sec_reg     <= '0;
            press_reg   <= '0;
            timeout_reg <= '0;
            led_reg     <= '0;
            po_reg      <= '0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            sec_reg     <= sec_next;
            press_reg   <= press_next;
            timeout_reg <= timeout_next;
            led_reg     <= led_next;
            po_reg      <= po_next;
        end
    end

    always_comb
    begin
        res_word.machine_state    = phase_code(phase_next);
        res_word.host_power       = po_next[PO_HOST];
        res_word.nfc_power        = po_next[PO_NFC];
        res_word.shutdown_request = po_next[PO_SDREQ];
        res_word.led_zero         = led_next[0];
        res_word.led_one          = led_next[1];
        res_word.led_two          = led_next[2];
    end

endmodule

>>> hdl/pwrseq_obuf.sv
// ----------------------------------------------------------------------------
// pwrseq_obuf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
module pwrseq_obuf (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    input  pwrseq_pkg::res_word_t   push_word,
    output logic                    push_ready,
    output logic                    out_valid,
    output pwrseq_pkg::res_word_t   out_word,
    input  logic                    out_ready,
    output pwrseq_pkg::obuf_sts_t   sts
);
    import pwrseq_pkg::*;

    res_word_t head_reg, head_next;
    res_word_t skid_reg, skid_next;
    logic      hv_reg,   hv_next;
    logic      sv_reg,   sv_next;
    logic      pop;

    assign pop        = hv_reg & out_ready;
    assign push_ready = ~sv_reg;

    always_comb
    begin
        head_next = head_reg;
        skid_next = skid_reg;
        hv_next   = hv_reg;
        sv_next   = sv_reg;
        if (pop)
        begin
            hv_next   = sv_reg;
            head_next = skid_reg;
            sv_next   = 1'b0;
        end
        if (push)
        begin
            if (!hv_next)
            begin
                hv_next   = 1'b1;
                head_next = push_word;
            end
            else
            begin
                sv_next   = 1'b1;
                skid_next = push_word;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hv_reg <= 1'b0;
            sv_reg <= 1'b0;
        end
        else
        begin
            hv_reg <= hv_next;
            sv_reg <= sv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        skid_reg <= skid_next;
    end

    assign out_valid      = hv_reg;
    assign out_word       = head_reg;
    assign sts.head_valid = hv_reg;
    assign sts.skid_valid = sv_reg;

endmodule
